@@ rtl/ttd_pkg.sv @@
// Shared constants and types for the two-band tone energy detector.
package ttd_pkg;

   localparam int IDX_W = 8;
   localparam int MAG_W = 16;
   localparam int ACC_W = 19;
   localparam int HW_W  = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 19;

   localparam logic [CSR_ADDR_W-1:0] CSR_BIN_OFFSET       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_WIDTH       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW_BAND_CENTRE  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIGH_BAND_CENTRE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_THRESHOLD  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT_FLAG      = 3'd5;

   localparam logic [IDX_W-1:0] RST_LOW_CENTRE  = 8'd89;
   localparam logic [IDX_W-1:0] RST_HIGH_CENTRE = 8'd111;
   localparam logic [ACC_W-1:0] RST_THRESHOLD   = 19'd40000;

   localparam int DEF_WINDOW_LEN = 8;
   localparam int unsigned BIN_COUNT = 256;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   typedef struct packed {
      logic [ACC_W-1:0] high_band_average;
      logic [ACC_W-1:0] low_band_average;
      logic             tone_flag;
   } rsp_type;

endpackage

@@ rtl/ttd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ttd_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/two_band_tone_energy_detector.sv @@
// Top level of the two-band tone energy detector.
//
// Spectrum bins arrive on the req_ stream, one per request: tdata carries the
// bin index and magnitude, tlast marks the last bin of a frame. Bins inside
// either band add their magnitude above the noise floor to that band's
// saturating sum. At the last bin both sums go into a window history held in
// a RAM, the window totals are updated, and one result per frame leaves on
// the rsp_ stream: the tone flag and the two window averages.
// The block takes one bin per cycle while req_tready is high. A result is valid
// on rsp_ once its last bin has passed the history read, which starts at the
// accepting edge, the total update, the reciprocal multiply for the average
// and the write into the output queue. Up to eight results may be
// outstanding; req_tready drops only while eight frames are pending in the
// pipeline and the queue, so a stalled receiver holds back the bin stream.
// Frames of any length, down to a single bin, follow back to back.
// Reset is synchronous and restores the register defaults, clears the band
// sums, totals and history (through per-entry valid bits, no clearing pass)
// and empties the queue. The csr_ port writes a register at each clock edge
// with csr_we high; write it only while no frame is in flight.
module two_band_tone_energy_detector import ttd_pkg::*; #(
   parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // bin_index[7:0], magnitude[23:8]
   input  logic                  req_tlast,   // frame_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // tone_flag[0], low_band_average[19:1],
                                              // high_band_average[38:20], zero[39]
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int LOG_W   = $clog2(WINDOW_LEN);
   localparam int TOT_W   = ACC_W + LOG_W;
   localparam int SHIFT   = TOT_W + LOG_W;
   localparam int RECIP_W = TOT_W + 1;
   localparam int PROD_W  = TOT_W + RECIP_W;
   localparam int HIST_W  = 2 * ACC_W;
   // Rounded-up reciprocal: exact floor division for every total below 2**TOT_W.
   localparam logic [63:0] RECIP_L =
      ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
   localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(WINDOW_LEN - 1);

   // Configuration registers.
   logic [MAG_W-1:0] offset_ff;
   logic [HW_W-1:0]  half_ff;
   logic [IDX_W-1:0] lo_ctr_ff;
   logic [IDX_W-1:0] hi_ctr_ff;
   logic [ACC_W-1:0] thr_ff;
   logic             inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         half_ff   <= '0;
         lo_ctr_ff <= RST_LOW_CENTRE;
         hi_ctr_ff <= RST_HIGH_CENTRE;
         thr_ff    <= RST_THRESHOLD;
         inv_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BIN_OFFSET:       offset_ff <= csr_wdata[MAG_W-1:0];
            CSR_HALF_WIDTH:       half_ff   <= csr_wdata[HW_W-1:0];
            CSR_LOW_BAND_CENTRE:  lo_ctr_ff <= csr_wdata[IDX_W-1:0];
            CSR_HIGH_BAND_CENTRE: hi_ctr_ff <= csr_wdata[IDX_W-1:0];
            CSR_LEVEL_THRESHOLD:  thr_ff    <= csr_wdata[ACC_W-1:0];
            CSR_INVERT_FLAG:      inv_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Bin stage: band membership and saturating accumulation.
   logic [IDX_W-1:0] idx;
   logic [MAG_W-1:0] mag;
   logic             req_acc;
   logic             frame_acc;
   logic             in_range;
   logic             pos;
   logic [MAG_W-1:0] excess;
   logic [IDX_W:0]   idx_hi;
   logic             lo_hit;
   logic             hi_hit;
   logic [ACC_W:0]   lo_sum;
   logic [ACC_W:0]   hi_sum;
   logic [ACC_W-1:0] lo_acc_ff;
   logic [ACC_W-1:0] hi_acc_ff;
   logic [ACC_W-1:0] lo_acc_in;
   logic [ACC_W-1:0] hi_acc_in;

   assign idx       = req_tdata[IDX_W-1:0];
   assign mag       = req_tdata[IDX_W +: MAG_W];
   assign req_acc   = req_tvalid && req_tready;
   assign frame_acc = req_acc && req_tlast;
   assign in_range  = 32'(idx) < BIN_COUNT;
   assign pos       = mag > offset_ff;
   assign excess    = mag - offset_ff;
   assign idx_hi    = {1'b0, idx} + {{(IDX_W-1){1'b0}}, half_ff};
   // Compared on nine bits, so a band near bin zero does not wrap.
   assign lo_hit = (idx_hi >= {1'b0, lo_ctr_ff}) &&
                   ({1'b0, idx} <= {1'b0, lo_ctr_ff} + {{(IDX_W-1){1'b0}}, half_ff});
   assign hi_hit = (idx_hi >= {1'b0, hi_ctr_ff}) &&
                   ({1'b0, idx} <= {1'b0, hi_ctr_ff} + {{(IDX_W-1){1'b0}}, half_ff});
   assign lo_sum = {1'b0, lo_acc_ff} + (ACC_W+1)'(excess);
   assign hi_sum = {1'b0, hi_acc_ff} + (ACC_W+1)'(excess);

   always_comb begin
      lo_acc_in = lo_acc_ff;
      hi_acc_in = hi_acc_ff;
      if (in_range && pos && lo_hit) begin
         lo_acc_in = lo_sum[ACC_W] ? '1 : lo_sum[ACC_W-1:0];
      end
      if (in_range && pos && hi_hit) begin
         hi_acc_in = hi_sum[ACC_W] ? '1 : hi_sum[ACC_W-1:0];
      end
   end

   logic             s1_vld_ff;
   logic [ACC_W-1:0] s1_lo_ff;
   logic [ACC_W-1:0] s1_hi_ff;
   logic [PTR_W-1:0] s1_ptr_ff;
   logic [PTR_W-1:0] ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_acc_ff <= '0;
         hi_acc_ff <= '0;
         ptr_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= frame_acc;
         if (req_acc) begin
            lo_acc_ff <= req_tlast ? '0 : lo_acc_in;
            hi_acc_ff <= req_tlast ? '0 : hi_acc_in;
         end
         if (frame_acc) begin
            ptr_ff <= (ptr_ff == LAST_PTR) ? '0 : ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_acc) begin
         s1_lo_ff  <= lo_acc_in;
         s1_hi_ff  <= hi_acc_in;
         s1_ptr_ff <= ptr_ff;
      end
   end

   // History RAM: read at the current pointer every cycle, written by the
   // total update stage. An entry never written since reset reads as zero.
   logic [HIST_W-1:0]     ram_rd;
   logic [HIST_W-1:0]     wr_data;
   logic [WINDOW_LEN-1:0] valid_ff;
   logic                  old_vld_ff;
   logic                  fwd_ff;
   logic [HIST_W-1:0]     fwd_data_ff;
   logic [HIST_W-1:0]     old;

   assign wr_data = {s1_hi_ff, s1_lo_ff};

   ttd_ram #(
      .WIDTH (HIST_W),
      .DEPTH (WINDOW_LEN)
   ) u_hist (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_ptr_ff),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         old_vld_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         old_vld_ff <= valid_ff[ptr_ff];
         // The RAM returns stale data when the read hits the entry written now.
         fwd_ff     <= s1_vld_ff && (s1_ptr_ff == ptr_ff);
         if (s1_vld_ff) begin
            valid_ff[s1_ptr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

   assign old = fwd_ff ? fwd_data_ff : (old_vld_ff ? ram_rd : '0);

   // Window totals.
   logic [TOT_W-1:0] lo_tot_ff;
   logic [TOT_W-1:0] hi_tot_ff;
   logic [TOT_W-1:0] lo_tot_in;
   logic [TOT_W-1:0] hi_tot_in;
   logic             s2_vld_ff;

   assign lo_tot_in = lo_tot_ff - TOT_W'(old[ACC_W-1:0]) + TOT_W'(s1_lo_ff);
   assign hi_tot_in = hi_tot_ff - TOT_W'(old[HIST_W-1:ACC_W]) + TOT_W'(s1_hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_tot_ff <= '0;
         hi_tot_ff <= '0;
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
         if (s1_vld_ff) begin
            lo_tot_ff <= lo_tot_in;
            hi_tot_ff <= hi_tot_in;
         end
      end
   end

   // Average by reciprocal multiply; the totals hold this frame's values here.
   logic [PROD_W-1:0] lo_prod_ff;
   logic [PROD_W-1:0] hi_prod_ff;
   logic              s3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_prod_ff <= PROD_W'(lo_tot_ff) * PROD_W'(RECIP);
      hi_prod_ff <= PROD_W'(hi_tot_ff) * PROD_W'(RECIP);
   end

   rsp_type          result;
   logic [ACC_W-1:0] lo_avg;
   logic [ACC_W-1:0] hi_avg;

   assign lo_avg = lo_prod_ff[SHIFT +: ACC_W];
   assign hi_avg = hi_prod_ff[SHIFT +: ACC_W];

   always_comb begin
      result.low_band_average  = lo_avg;
      result.high_band_average = hi_avg;
      result.tone_flag         = ((lo_avg < thr_ff) && (hi_avg < thr_ff)) ^ inv_ff;
   end

   // Output queue. pending_ff counts frames accepted whose result is not yet
   // taken, so the queue always has room for everything in the pipeline.
   rsp_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff;
   logic [FIFO_CNT_W-1:0] pending_ff;
   logic                  pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign req_tready = pending_ff < FIFO_CNT_W'(FIFO_DEPTH);
   assign rsp_tdata  = {1'b0, fifo_ff[rd_ptr_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         pending_ff  <= '0;
      end else begin
         if (s3_vld_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_W'(s3_vld_ff) - FIFO_CNT_W'(pop);
         pending_ff  <= pending_ff + FIFO_CNT_W'(frame_acc) - FIFO_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_vld_ff) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> (fifo_cnt_ff < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

   a_pending_covers_queue: assert property (@(posedge clock) disable iff (reset)
      pending_ff >= fifo_cnt_ff)
      else $error("pending count below queue fill");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      frame_acc |=> (lo_acc_ff == '0) && (hi_acc_ff == '0))
      else $error("band sums not cleared after frame end");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      frame_acc |=> ##2 s3_vld_ff)
      else $error("frame result lost in pipeline");

   a_entry_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |=> valid_ff[$past(s1_ptr_ff)])
      else $error("history entry not marked valid");
`endif

endmodule
